/* rtl/pai_pkg.sv */
// Package with the widths, codes and states of the positional array store.
`default_nettype none
package pai_pkg;

  localparam int CAPACITY = 64;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam int OPCODE_W = 2;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT   = 2'd0,
    OP_DELETE   = 2'd1,
    OP_TRAVERSE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_BADPOS    = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_DEL_GET,
    S_DEL_GOT,
    S_DEL_RD,
    S_DEL_WR,
    S_TRV_RD,
    S_TRV_OUT,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

/* rtl/pai_if.sv */
// Channel interfaces for the command items and the result items.
`default_nettype none
interface pai_in_if import pai_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic [POS_W-1:0]           position;
  logic signed [VALUE_W-1:0]  value;

  modport source(output valid, output opcode, output position, output value, input ready);
  modport sink(input valid, input opcode, input position, input value, output ready);
endinterface

interface pai_out_if import pai_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic signed [VALUE_W-1:0]  data;
  logic [POS_W-1:0]           index;
  logic                       last;

  modport source(output valid, output status, output data, output index, output last,
                 input ready);
  modport sink(input valid, input status, input data, input index, input last,
               output ready);
endinterface
`default_nettype wire

/* rtl/pai_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module pai_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* rtl/positional_array_insert_delete.sv */
// Top level of the positional array store: sequencer, shared index unit and element RAM.
//
//   channel   direction  fields                          handshake
//   in_ch     sink       opcode, position, value         valid/ready
//   out_ch    source     status, data, index, last       valid/ready
//
// An error passes through the emit state to the result register, and an unused opcode is
// dropped in its accept cycle. An insert at position p with n entries stored moves the
// n-p entries from p upward, a delete moves the entries behind p down, and a traverse gives
// out one entry per read; each moved entry costs one read and one write of the element RAM.
// Reset clears the count, the sequencer and the result valid flag only; the RAM needs no
// clearing because only entries below the count are ever read.
// A stall on the result side holds the sequencer in its output state; no new item is
// taken until the sequencer is back in idle.
`default_nettype none
module positional_array_insert_delete import pai_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pai_in_if.sink     in_ch,
  pai_out_if.source  out_ch
);

  state_t                     state_r, state_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [CW-1:0]              idx_r, idx_nxt;
  logic [POS_W-1:0]           pos_r, pos_nxt;
  logic [VALUE_W-1:0]         val_r, val_nxt;
  logic [VALUE_W-1:0]         got_r, got_nxt;
  status_t                    res_status_r, res_status_nxt;
  logic [VALUE_W-1:0]         res_data_r, res_data_nxt;
  logic [POS_W-1:0]           res_index_r, res_index_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]        out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]         out_data_r, out_data_nxt;
  logic [POS_W-1:0]           out_index_r, out_index_nxt;
  logic                       out_last_r, out_last_nxt;

  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [VALUE_W-1:0]         ram_wdata, ram_rdata;

  // The shared index stepper: the index steps down while an insert opens a gap
  // and up for deletes and traversal.
  logic                       step_down;
  logic [CW-1:0]              idx_step;
  logic                       out_free;
  logic [POS_W:0]             pos_in_ext, pos_r_ext, count_ext, idx_ext;

  assign step_down = (state_r == S_INS_RD) || (state_r == S_INS_WR);
  assign idx_step  = idx_r + (step_down ? {CW{1'b1}} : CW'(1));
  assign out_free  = !out_valid_r || out_ch.ready;

  assign pos_in_ext = (POS_W + 1)'(in_ch.position);
  assign pos_r_ext  = (POS_W + 1)'(pos_r);
  assign count_ext  = (POS_W + 1)'(count_r);
  assign idx_ext    = (POS_W + 1)'(idx_r);

  pai_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    got_r        <= got_nxt;
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
    res_index_r  <= res_index_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_index_r  <= out_index_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_comb begin
    logic out_load;
    out_load       = 1'b0;
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    got_nxt        = got_r;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    res_index_nxt  = res_index_r;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_index_nxt  = out_index_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r[AW-1:0];
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = idx_step[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          pos_nxt       = in_ch.position;
          val_nxt       = in_ch.value;
          res_data_nxt  = '0;
          res_index_nxt = in_ch.position;
          unique case (in_ch.opcode)
            OP_INSERT: begin
              // The full check comes before the position check.
              if (count_r == CW'(CAPACITY)) begin
                res_status_nxt = ST_OVERFLOW;
                state_nxt      = S_EMIT;
              end else if (pos_in_ext > count_ext) begin
                res_status_nxt = ST_BADPOS;
                state_nxt      = S_EMIT;
              end else begin
                idx_nxt   = count_r;
                state_nxt = S_INS_RD;
              end
            end
            OP_DELETE: begin
              if (count_r == '0) begin
                res_status_nxt = ST_UNDERFLOW;
                state_nxt      = S_EMIT;
              end else if (pos_in_ext >= count_ext) begin
                res_status_nxt = ST_BADPOS;
                state_nxt      = S_EMIT;
              end else begin
                state_nxt = S_DEL_GET;
              end
            end
            OP_TRAVERSE: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
                res_index_nxt  = '0;
                state_nxt      = S_EMIT;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_TRV_RD;
              end
            end
            default: begin
              // The unused opcode is dropped without a result.
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_INS_RD: begin
        if (idx_ext == pos_r_ext) begin
          ram_we         = 1'b1;
          ram_wdata      = val_r;
          count_nxt      = count_r + CW'(1);
          res_status_nxt = ST_OK;
          state_nxt      = S_EMIT;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        ram_we    = 1'b1;
        idx_nxt   = idx_step;
        state_nxt = S_INS_RD;
      end
      S_DEL_GET: begin
        ram_re    = 1'b1;
        ram_raddr = pos_r[AW-1:0];
        state_nxt = S_DEL_GOT;
      end
      S_DEL_GOT: begin
        got_nxt   = ram_rdata;
        idx_nxt   = pos_r[CW-1:0];
        state_nxt = S_DEL_RD;
      end
      S_DEL_RD: begin
        if (idx_step == count_r) begin
          count_nxt      = count_r - CW'(1);
          res_status_nxt = ST_OK;
          res_data_nxt   = got_r;
          state_nxt      = S_EMIT;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        ram_we    = 1'b1;
        idx_nxt   = idx_step;
        state_nxt = S_DEL_RD;
      end
      S_TRV_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_r[AW-1:0];
        state_nxt = S_TRV_OUT;
      end
      S_TRV_OUT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = ST_OK;
          out_data_nxt   = ram_rdata;
          out_index_nxt  = POS_W'(idx_r);
          out_last_nxt   = (idx_step == count_r);
          if (idx_step == count_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_step;
            state_nxt = S_TRV_RD;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = res_status_r;
          out_data_nxt   = res_data_r;
          out_index_nxt  = res_index_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.data   = out_data_r;
  assign out_ch.index  = out_index_r;
  assign out_ch.last   = out_last_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(count_r) |-> (count_r == $past(count_r) + CW'(1)) ||
                          (count_r == $past(count_r) - CW'(1)))
    else $error("entry count changed by more than one");

  a_trv_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TRV_OUT) |-> (idx_r < count_r))
    else $error("traversal index beyond stored entries");

  a_write_addr: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((AW + 1)'(ram_waddr) < (AW + 1)'(CAPACITY)))
    else $error("store write outside capacity");

  a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) && !out_free |=> (state_r == S_EMIT))
    else $error("pending result left its state while the output was busy");
`endif

endmodule
`default_nettype wire

/* verif/positional_array_insert_delete_test.sv */
// Self-checking testbench for the positional array store: insert, delete and traverse items.
`timescale 1ns / 1ps
module positional_array_insert_delete_test;
  import pai_pkg::*;

  // The package names only the three live opcodes; the fourth code must be ignored.
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  // Sized from the capacity, so that a full-depth shift, the slowest item, fits in the tail wait.
  localparam int TAIL_CYCLES     = 2 * CAPACITY + 10;
  // The long receiver stall below is the longest legal stretch without any handshake.
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 4000;

  typedef struct packed {
    logic [OPCODE_W-1:0]       opcode;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
  } array_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] data;
    logic [POS_W-1:0]          index;
    logic                      last;
  } array_result_t;

  logic clk;
  logic rst_n;

  pai_in_if  in_ch ();
  pai_out_if out_ch ();

  positional_array_insert_delete dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Items waiting to be offered, and the results that accepted items still owe.
  array_cmd_t    cmd_backlog [$];
  array_result_t due_results [$];

  // Our own copy of the store, updated at the moment an item is accepted.
  logic signed [VALUE_W-1:0] mirror [CAPACITY];
  int mirror_count = 0;
  int peak_count   = 0;

  // The stimulus side tracks the fill level it expects, so that it can aim positions
  // at the valid range while items are still queued.
  int plan_count = 0;

  int err_count     = 0;
  int checked_count = 0;
  int op_seen [4];
  int status_seen [5];

  // Knobs that the stimulus turns; the driver reads the first, the monitor reads both.
  bit idle_enable   = 1'b0;
  bit hold_off_req  = 1'b0;

  array_cmd_t offered = '0;
  int send_gap   = 0;
  int stall_left = 0;
  int hold_left  = 0;
  bit hold_off_begun = 1'b0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every input of the block is known from time zero, and reset is asserted from the start.
  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.opcode    = '0;
    in_ch.position  = '0;
    in_ch.value     = '0;
    out_ch.ready    = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Gap lengths come from three bands: the shortest most often, the longest rarely.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Values lean on the extremes of the signed range now and then.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(VALUE_W-1){1'b0}}};
      1: return {1'b0, {(VALUE_W-1){1'b1}}};
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // A position inside 0..hi most of the time, with the ends favored; otherwise (or when
  // there is no valid position) anything the field can hold.
  function automatic logic [POS_W-1:0] pick_position(input int hi);
    if (hi < 0 || $urandom_range(0, 99) < 12) return POS_W'($urandom_range(0, 127));
    case ($urandom_range(0, 3))
      0: return '0;
      1: return POS_W'(hi);
      default: return POS_W'($urandom_range(0, hi));
    endcase
  endfunction

  // Applies one accepted item to the mirror and queues the results it must produce.
  task automatic apply_to_mirror(input array_cmd_t c);
    array_result_t r;
    int i;
    r.status = ST_OK;
    r.data   = '0;
    r.index  = c.position;
    r.last   = 1'b1;
    op_seen[c.opcode]++;
    case (c.opcode)
      OP_INSERT: begin
        // A full store is reported before the position is looked at.
        if (mirror_count >= CAPACITY) begin
          r.status = ST_OVERFLOW;
        end else if (c.position > mirror_count) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = mirror_count; i > c.position; i--) mirror[i] = mirror[i-1];
          mirror[c.position] = c.value;
          mirror_count++;
          if (mirror_count > peak_count) peak_count = mirror_count;
        end
        status_seen[r.status]++;
        due_results.push_back(r);
      end
      OP_DELETE: begin
        // Likewise an empty store wins over a bad position.
        if (mirror_count == 0) begin
          r.status = ST_UNDERFLOW;
        end else if (c.position >= mirror_count) begin
          r.status = ST_BADPOS;
        end else begin
          r.data = mirror[c.position];
          for (i = c.position; i + 1 < mirror_count; i++) mirror[i] = mirror[i+1];
          mirror_count--;
        end
        status_seen[r.status]++;
        due_results.push_back(r);
      end
      OP_TRAVERSE: begin
        if (mirror_count == 0) begin
          r.status = ST_EMPTY;
          r.index  = '0;
          status_seen[r.status]++;
          due_results.push_back(r);
        end else begin
          for (i = 0; i < mirror_count; i++) begin
            r.data  = mirror[i];
            r.index = i[POS_W-1:0];
            r.last  = (i == mirror_count - 1);
            due_results.push_back(r);
          end
          status_seen[ST_OK]++;
        end
      end
      default: begin
        // The unused opcode leaves the store alone and owes nothing.
      end
    endcase
  endtask

  // Compares the result item on the output channel with the oldest one owed.
  task automatic check_result();
    array_result_t got;
    array_result_t want;
    got.status = out_ch.status;
    got.data   = out_ch.data;
    got.index  = out_ch.index;
    got.last   = out_ch.last;
    if (due_results.size() == 0) begin
      err_count++;
      $display("%0t: unexpected result, got status %0d data %0d index %0d last %0d",
               $time, got.status, got.data, got.index, got.last);
    end else begin
      want = due_results.pop_front();
      checked_count++;
      if (got !== want) begin
        err_count++;
        // Fields are shown as status/data/index/last.
        $display("%0t: result mismatch, expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                 $time, want.status, want.data, want.index, want.last,
                 got.status, got.data, got.index, got.last);
      end
    end
  endtask

  // Driver: offers items from the backlog. When an item is taken, it is handed to the
  // mirror in the same edge, and the next one is loaded after an optional random gap.
  // The valid line gets exactly one assignment per edge, so back-to-back items keep it high.
  always @(posedge clk) begin : driver
    logic offering;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      offering = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        apply_to_mirror(offered);
        offering = 1'b0;
        send_gap = (idle_enable && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (cmd_backlog.size() > 0) begin
          offered  = cmd_backlog.pop_front();
          offering = 1'b1;
        end
      end
      in_ch.valid    <= offering;
      in_ch.opcode   <= offered.opcode;
      in_ch.position <= offered.position;
      in_ch.value    <= offered.value;
    end
  end

  // Monitor: checks every result item it takes and applies back-pressure. A hold-off
  // request from the stimulus starts one long stall, counted here, during which the
  // driver keeps offering so that the block backs up and stalls its input.
  always @(posedge clk) begin : monitor
    logic taking;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result();
      if (hold_off_req && !hold_off_begun) begin
        hold_off_begun = 1'b1;
        hold_left      = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        taking = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        taking = 1'b0;
      end else begin
        taking = 1'b1;
        if (idle_enable && $urandom_range(0, 99) < 12) stall_left = pick_gap();
      end
      out_ch.ready <= taking;
    end
  end

  // Watchdog: while anything is outstanding, count edges with no handshake on either side.
  always @(posedge clk) begin : watchdog
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                 (cmd_backlog.size() == 0 && !in_ch.valid && due_results.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles with %0d results still owed",
               $time, quiet_cycles, due_results.size());
      $display("** positional_array_insert_delete: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Queues one item and keeps the planned fill level in step with it.
  task automatic queue_cmd(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic signed [VALUE_W-1:0] val);
    array_cmd_t c;
    c.opcode   = op;
    c.position = pos;
    c.value    = val;
    cmd_backlog.push_back(c);
    if (op == OP_INSERT && plan_count < CAPACITY && pos <= plan_count) plan_count++;
    else if (op == OP_DELETE && plan_count > 0 && pos < plan_count) plan_count--;
  endtask

  // One random item for the mixed phases; insert_pct sets the drift of the fill level.
  task automatic queue_random_cmd(input int insert_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) queue_cmd(OP_UNUSED, POS_W'($urandom_range(0, 127)), $urandom);
    else if (r < 10) queue_cmd(OP_TRAVERSE, POS_W'($urandom_range(0, 127)), $urandom);
    else if (r < 10 + insert_pct * 90 / 100)
      queue_cmd(OP_INSERT, pick_position(plan_count), pick_value());
    else queue_cmd(OP_DELETE, pick_position(plan_count - 1), $urandom);
  endtask

  // Holds the sender back until everything queued has been taken and answered.
  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_backlog.size() > 0 || in_ch.valid || due_results.size() > 0);
  endtask

  // Stimulus. Changes are made at the falling edge, away from the edge where the
  // handshake processes look at them.
  initial begin : stimulus
    int k;
    int phase;
    int phase_bias [4];

    phase_bias = '{70, 30, 55, 45};
    do @(negedge clk); while (!rst_n);

    // Directed part, back to back: every error case on an empty store, then a small store
    // built at the front, middle and end and taken apart again from both ends.
    idle_enable = 1'b0;
    queue_cmd(OP_TRAVERSE, 7'd127, '1);
    queue_cmd(OP_DELETE,   7'd127, '0);
    queue_cmd(OP_DELETE,   7'd0,   '1);
    queue_cmd(OP_INSERT,   7'd1,   32'sd5);
    queue_cmd(OP_INSERT,   7'd127, 32'sd6);
    queue_cmd(OP_INSERT,   7'd0,   {1'b1, {(VALUE_W-1){1'b0}}});
    queue_cmd(OP_INSERT,   7'd1,   {1'b0, {(VALUE_W-1){1'b1}}});
    queue_cmd(OP_INSERT,   7'd0,   '1);
    queue_cmd(OP_INSERT,   7'd1,   '0);
    queue_cmd(OP_UNUSED,   7'd127, '1);
    queue_cmd(OP_TRAVERSE, 7'd127, '1);
    queue_cmd(OP_DELETE,   7'd4,   '0);
    queue_cmd(OP_DELETE,   7'd127, '0);
    queue_cmd(OP_DELETE,   7'd3,   '0);
    queue_cmd(OP_DELETE,   7'd0,   '0);
    queue_cmd(OP_TRAVERSE, 7'd0,   '0);
    queue_cmd(OP_DELETE,   7'd1,   '0);
    queue_cmd(OP_DELETE,   7'd0,   '0);
    queue_cmd(OP_TRAVERSE, 7'd0,   '0);
    wait_drained();

    // Fill the store to capacity at random positions, mostly valid ones, then try to overflow it.
    // The long receiver stall starts while these are still being offered.
    idle_enable = 1'b1;
    while (plan_count < CAPACITY) begin
      queue_cmd(OP_INSERT, pick_position(plan_count), pick_value());
    end
    queue_cmd(OP_INSERT, 7'd127, pick_value());
    queue_cmd(OP_INSERT, 7'd0, pick_value());
    queue_cmd(OP_INSERT, CAPACITY[POS_W-1:0], pick_value());
    hold_off_req = 1'b1;
    wait_drained();

    // A full traverse with no idling on either side.
    idle_enable = 1'b0;
    queue_cmd(OP_TRAVERSE, POS_W'($urandom_range(0, 127)), $urandom);
    wait_drained();

    // Empty the store again, with bad positions mixed in, then poke the empty store.
    idle_enable = 1'b1;
    queue_cmd(OP_DELETE, CAPACITY[POS_W-1:0], '0);
    queue_cmd(OP_DELETE, POS_W'(CAPACITY - 1), '0);
    while (plan_count > 0) begin
      if ($urandom_range(0, 99) < 10)
        queue_cmd(OP_DELETE, POS_W'($urandom_range(plan_count, 127)), $urandom);
      else queue_cmd(OP_DELETE, pick_position(plan_count - 1), $urandom);
    end
    queue_cmd(OP_DELETE, POS_W'($urandom_range(0, 127)), $urandom);
    queue_cmd(OP_TRAVERSE, POS_W'($urandom_range(0, 127)), $urandom);
    wait_drained();

    // Mixed phases that push the fill level up and down; the sender pauses between them
    // until every owed result has arrived, and every other phase runs without gaps.
    for (phase = 0; phase < 4; phase++) begin
      idle_enable = (phase % 2 == 0);
      for (k = 0; k < 50; k++) queue_random_cmd(phase_bias[phase]);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (due_results.size() != 0) begin
      err_count++;
      $display("%0t: %0d expected results never arrived", $time, due_results.size());
    end

    $display("Checked %0d results; items: %0d insert, %0d delete, %0d traverse, %0d unused.",
             checked_count, op_seen[OP_INSERT], op_seen[OP_DELETE], op_seen[OP_TRAVERSE],
             op_seen[OP_UNUSED]);
    $display("Fill peak %0d/%0d; ok %0d, overflow %0d, underflow %0d, bad pos %0d, empty %0d.",
             peak_count, CAPACITY, status_seen[ST_OK], status_seen[ST_OVERFLOW],
             status_seen[ST_UNDERFLOW], status_seen[ST_BADPOS], status_seen[ST_EMPTY]);
    if (err_count == 0) begin
      $display("** positional_array_insert_delete: PASSED **");
    end else begin
      $display("** positional_array_insert_delete: FAILED **");
    end
    $finish;
  end

endmodule
